FILE: rtl/core/ghc_pkg.sv
package ghc_pkg;

	localparam int COORD_BITS = 32;
	localparam int COUNT_BITS = 24;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	localparam int TURNS      = 4;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] corner0_x;
		logic signed [COORD_BITS-1:0] corner0_y;
		logic signed [COORD_BITS-1:0] corner1_x;
		logic signed [COORD_BITS-1:0] corner1_y;
		logic signed [COORD_BITS-1:0] corner2_x;
		logic signed [COORD_BITS-1:0] corner2_y;
		logic signed [COORD_BITS-1:0] corner3_x;
		logic signed [COORD_BITS-1:0] corner3_y;
		logic                         cell_invalid;
		logic                         last_cell;
	} cell_t;

	typedef struct packed {
		logic                  flip_needed;
		logic [COUNT_BITS-1:0] ok_total;
		logic [COUNT_BITS-1:0] wrong_total;
		logic [COUNT_BITS-1:0] invalid_total;
	} result_t;

	typedef struct packed {
		logic                                cell_invalid;
		logic                                last_cell;
		logic [TURNS-1:0][PROD_BITS-1:0]     left;
		logic [TURNS-1:0][PROD_BITS-1:0]     right;
	} turn_t;

endpackage

FILE: rtl/core/ghc_turn.sv
module ghc_turn (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           cell_valid,
	input  ghc_pkg::cell_t cell_req,
	output logic           turn_valid_s2,
	output ghc_pkg::turn_t turn_s2
);

	localparam int DB = ghc_pkg::DIFF_BITS;

	logic           cell_valid_s1;
	ghc_pkg::cell_t cell_s1;

	logic signed [ghc_pkg::COORD_BITS-1:0] xs [ghc_pkg::TURNS];
	logic signed [ghc_pkg::COORD_BITS-1:0] ys [ghc_pkg::TURNS];
	ghc_pkg::turn_t turn_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid_s1 <= 1'b0;
			turn_valid_s2 <= 1'b0;
		end else if (advance) begin
			cell_valid_s1 <= cell_valid;
			turn_valid_s2 <= cell_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cell_s1 <= cell_req;
			turn_s2 <= turn_d;
		end
	end

	assign xs[0] = cell_s1.corner0_x;
	assign ys[0] = cell_s1.corner0_y;
	assign xs[1] = cell_s1.corner1_x;
	assign ys[1] = cell_s1.corner1_y;
	assign xs[2] = cell_s1.corner2_x;
	assign ys[2] = cell_s1.corner2_y;
	assign xs[3] = cell_s1.corner3_x;
	assign ys[3] = cell_s1.corner3_y;

	always_comb begin
		logic signed [ghc_pkg::DIFF_BITS-1:0] dx1;
		logic signed [ghc_pkg::DIFF_BITS-1:0] dy1;
		logic signed [ghc_pkg::DIFF_BITS-1:0] dx2;
		logic signed [ghc_pkg::DIFF_BITS-1:0] dy2;
		logic signed [ghc_pkg::PROD_BITS-1:0] lprod;
		logic signed [ghc_pkg::PROD_BITS-1:0] rprod;
		turn_d              = '0;
		turn_d.cell_invalid = cell_s1.cell_invalid;
		turn_d.last_cell    = cell_s1.last_cell;
		for (int k = 0; k < ghc_pkg::TURNS; k++) begin
			dx1   = DB'(xs[(k + 1) % 4]) - DB'(xs[k]);
			dy1   = DB'(ys[(k + 1) % 4]) - DB'(ys[k]);
			dx2   = DB'(xs[(k + 2) % 4]) - DB'(xs[(k + 1) % 4]);
			dy2   = DB'(ys[(k + 2) % 4]) - DB'(ys[(k + 1) % 4]);
			lprod = dx1 * dy2;
			rprod = dy1 * dx2;
			turn_d.left[k]  = lprod;
			turn_d.right[k] = rprod;
		end
	end

endmodule

FILE: rtl/core/ghc_count.sv
module ghc_count (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             turn_valid_s2,
	input  ghc_pkg::turn_t   turn_s2,
	output logic             result_valid,
	output ghc_pkg::result_t result
);

	localparam int CB = ghc_pkg::COUNT_BITS;

	logic [CB-1:0] ok_q;
	logic [CB-1:0] wrong_q;
	logic [CB-1:0] invalid_q;
	logic [CB-1:0] ok_nx;
	logic [CB-1:0] wrong_nx;
	logic [CB-1:0] invalid_nx;
	logic [ghc_pkg::TURNS-1:0] turn_le;
	logic          good;
	logic          flip;
	logic          result_valid_q;
	ghc_pkg::result_t result_q;

	function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] c);
		sat_inc = (c == '1) ? c : c + CB'(1);
	endfunction

	always_comb begin
		for (int k = 0; k < ghc_pkg::TURNS; k++) begin
			turn_le[k] = $signed(turn_s2.left[k]) <= $signed(turn_s2.right[k]);
		end
	end

	assign good = &turn_le;

	always_comb begin
		ok_nx      = ok_q;
		wrong_nx   = wrong_q;
		invalid_nx = invalid_q;
		if (turn_s2.cell_invalid) begin
			invalid_nx = sat_inc(invalid_q);
		end else if (good) begin
			ok_nx = sat_inc(ok_q);
		end else begin
			wrong_nx = sat_inc(wrong_q);
		end
	end

	assign flip = {1'b0, wrong_nx} > {ok_nx, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q           <= '0;
			wrong_q        <= '0;
			invalid_q      <= '0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= turn_valid_s2 && turn_s2.last_cell;
			if (turn_valid_s2) begin
				if (turn_s2.last_cell) begin
					ok_q      <= '0;
					wrong_q   <= '0;
					invalid_q <= '0;
				end else begin
					ok_q      <= ok_nx;
					wrong_q   <= wrong_nx;
					invalid_q <= invalid_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && turn_valid_s2 && turn_s2.last_cell) begin
			result_q.flip_needed   <= flip;
			result_q.ok_total      <= ok_nx;
			result_q.wrong_total   <= wrong_nx;
			result_q.invalid_total <= invalid_nx;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: rtl/core/grid_handedness_check_unit.sv
// channel  | valid        | ready        | request
// cell     | cell_valid   | cell_ready   | cell_req (ghc_pkg::cell_t)
// result   | result_valid | result_ready | result   (ghc_pkg::result_t)
//
// One cell per cycle while no result is stalled; a result is registered once its last cell has passed the stages below.
// Stages: input register, product register (eight exact products), count and result register.
// arst_n clears all valid bits and the three counters.
// A stalled result holds the whole pipe; cell_ready is low only while that result waits.
module grid_handedness_check_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cell_valid,
	output logic             cell_ready,
	input  ghc_pkg::cell_t   cell_req,
	output logic             result_valid,
	input  logic             result_ready,
	output ghc_pkg::result_t result
);

	logic           advance;
	logic           turn_valid_s2;
	ghc_pkg::turn_t turn_s2;

	assign advance    = !result_valid || result_ready;
	assign cell_ready = advance;

	ghc_turn u_turn (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.cell_valid    (cell_valid),
		.cell_req      (cell_req),
		.turn_valid_s2 (turn_valid_s2),
		.turn_s2       (turn_s2)
	);

	ghc_count u_count (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.turn_valid_s2 (turn_valid_s2),
		.turn_s2       (turn_s2),
		.result_valid  (result_valid),
		.result        (result)
	);

endmodule

FILE: rtl/core/ghc_checker.sv
module ghc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             cell_valid,
	input logic             cell_ready,
	input ghc_pkg::cell_t   cell_req,
	input logic             result_valid,
	input logic             result_ready,
	input ghc_pkg::result_t result
);

	logic cell_seen;
	assign cell_seen = cell_valid || cell_req.last_cell;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> cell_ready)
		else $error("cell_ready low with no result waiting");

	a_flip_rule: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.flip_needed ==
			({1'b0, result.wrong_total} > {result.ok_total, 1'b0}))
		else $error("flip_needed disagrees with totals");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !cell_ready || !cell_seen)
		else $error("cell taken while result stalled");

endmodule

bind grid_handedness_check_unit ghc_checker u_ghc_checker (.*);
